@@ hw/rtl/m3inv_pkg.sv @@
// ----------------------------------------------------------------------------
// m3inv_pkg: 3x3 matrix inverse shared types and constants
// Formats, datapath widths, cofactor index tables and transaction payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package m3inv_pkg;

  localparam int DW     = 32;          // entry width
  localparam int FB     = 16;          // fraction bits
  localparam int NE     = 9;           // entries per matrix
  localparam int IDX_W  = 4;           // index into the nine entries
  localparam int PROD_W = 2 * DW;      // entry x entry
  localparam int COF_W  = 2 * DW + 1;  // a*b - c*d
  localparam int LO_W   = DW + 1;      // low slice of a cofactor (unsigned)
  localparam int HI_W   = COF_W - LO_W;
  localparam int PLO_W  = DW + LO_W + 1;
  localparam int DET_W  = 3 * DW + 3;  // exact determinant
  localparam int QB     = DW + 2;      // quotient bits, one guard for rounding
  localparam int XW     = COF_W + 2 * FB + 1;
  localparam int DSW    = DET_W + QB;
  localparam int DIVW   = (XW > DSW) ? XW : DSW;

  // cofactor k = m[A]*m[B] - m[C]*m[D]; k and entry indexes are 3*col + row
  localparam logic [IDX_W-1:0] COF_A [NE] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0,
                                              4'd3, 4'd3, 4'd6, 4'd0};
  localparam logic [IDX_W-1:0] COF_B [NE] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8,
                                              4'd2, 4'd7, 4'd1, 4'd4};
  localparam logic [IDX_W-1:0] COF_C [NE] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6,
                                              4'd0, 4'd6, 4'd0, 4'd3};
  localparam logic [IDX_W-1:0] COF_D [NE] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2,
                                              4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    logic signed [DW-1:0] in_c0_r0;
    logic signed [DW-1:0] in_c0_r1;
    logic signed [DW-1:0] in_c0_r2;
    logic signed [DW-1:0] in_c1_r0;
    logic signed [DW-1:0] in_c1_r1;
    logic signed [DW-1:0] in_c1_r2;
    logic signed [DW-1:0] in_c2_r0;
    logic signed [DW-1:0] in_c2_r1;
    logic signed [DW-1:0] in_c2_r2;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] out_c0_r0;
    logic signed [DW-1:0] out_c0_r1;
    logic signed [DW-1:0] out_c0_r2;
    logic signed [DW-1:0] out_c1_r0;
    logic signed [DW-1:0] out_c1_r1;
    logic signed [DW-1:0] out_c1_r2;
    logic signed [DW-1:0] out_c2_r0;
    logic signed [DW-1:0] out_c2_r1;
    logic signed [DW-1:0] out_c2_r2;
    logic                 singular;
    logic                 overflowed;
  } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/matrix3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined 3x3 fixed-point matrix inverse
// Adjugate times reciprocal determinant, exact up to one final rounding,
// saturated to signed Q16.16, one matrix accepted per clock.
// ----------------------------------------------------------------------------
//  channel   | ports                 | transaction taken when
//  ----------+-----------------------+---------------------------------------
//  request   | start, busy, operand  | rising edge with start=1 and busy=0
//  response  | done, result          | rising edge ending the done=1 cycle
//
//  Fully pipelined: busy is always low, a new matrix may enter every cycle.
//  The 34-stage restoring divider (one quotient bit per stage, nine lanes side
//  by side) makes up most of the pipeline, after the six front stages.
//  Synchronous reset clears only the valid bits; in-flight transactions drop.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_inverse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire m3inv_pkg::in_t  operand,
  output logic                 done,
  output m3inv_pkg::out_t      result
);

  // entries, indexed 3*col + row
  logic signed [m3inv_pkg::DW-1:0] m [m3inv_pkg::NE];

  assign m[0] = operand.in_c0_r0;
  assign m[1] = operand.in_c0_r1;
  assign m[2] = operand.in_c0_r2;
  assign m[3] = operand.in_c1_r0;
  assign m[4] = operand.in_c1_r1;
  assign m[5] = operand.in_c1_r2;
  assign m[6] = operand.in_c2_r0;
  assign m[7] = operand.in_c2_r1;
  assign m[8] = operand.in_c2_r2;

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---- stage 1: 18 cofactor products -------------------------------------
  logic                               v1;
  logic signed [m3inv_pkg::PROD_W-1:0] pab [m3inv_pkg::NE];
  logic signed [m3inv_pkg::PROD_W-1:0] pcd [m3inv_pkg::NE];
  logic signed [m3inv_pkg::DW-1:0]     e1  [3];   // first-row entries for det

  // ---- stage 2: cofactors ------------------------------------------------
  logic                               v2;
  logic signed [m3inv_pkg::COF_W-1:0] cof2 [m3inv_pkg::NE];
  logic signed [m3inv_pkg::DW-1:0]    e2   [3];

  // ---- stage 3: determinant partial products (cofactor split hi/lo) ------
  logic                               v3;
  logic signed [m3inv_pkg::COF_W-1:0] cof3 [m3inv_pkg::NE];
  logic signed [m3inv_pkg::PLO_W-1:0] plo  [3];
  logic signed [m3inv_pkg::PROD_W-1:0] phi [3];

  // ---- stage 4: recombined terms -----------------------------------------
  logic                               v4;
  logic signed [m3inv_pkg::COF_W-1:0] cof4 [m3inv_pkg::NE];
  logic signed [m3inv_pkg::DET_W-1:0] dterm [3];

  // ---- stage 5: determinant ----------------------------------------------
  logic                               v5;
  logic signed [m3inv_pkg::COF_W-1:0] cof5 [m3inv_pkg::NE];
  logic signed [m3inv_pkg::DET_W-1:0] det5;

  // ---- stage 6: magnitudes and signs -------------------------------------
  logic                               v6;
  logic                               sing6;
  logic [m3inv_pkg::DET_W-1:0]        dmag6;
  logic [m3inv_pkg::COF_W-1:0]        nmag6 [m3inv_pkg::NE];
  logic                               sgn6  [m3inv_pkg::NE];

  // ---- divider pipe: index 0 is stage 7, QB is its last stage ------------
  logic                               dv    [m3inv_pkg::QB+1];
  logic                               dsing [m3inv_pkg::QB+1];
  logic [m3inv_pkg::DET_W-1:0]        dd    [m3inv_pkg::QB+1];
  logic [m3inv_pkg::DIVW-1:0]         rem   [m3inv_pkg::QB+1][m3inv_pkg::NE];
  logic [m3inv_pkg::QB-1:0]           quo   [m3inv_pkg::QB+1][m3inv_pkg::NE];
  logic                               dsg   [m3inv_pkg::QB+1][m3inv_pkg::NE];
  logic                               dov   [m3inv_pkg::QB+1][m3inv_pkg::NE];

  logic [m3inv_pkg::DIVW-1:0] num_x  [m3inv_pkg::NE];
  logic [m3inv_pkg::DIVW-1:0] dtop;

  always_comb begin
    dtop = m3inv_pkg::DIVW'(dmag6) << m3inv_pkg::QB;
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      num_x[k] = m3inv_pkg::DIVW'(nmag6[k]) << (2 * m3inv_pkg::FB + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      for (int j = 0; j <= m3inv_pkg::QB; j++) dv[j] <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      dv[0] <= v6;
      for (int j = 0; j < m3inv_pkg::QB; j++) dv[j+1] <= dv[j];
    end

    // stage 1
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      pab[k] <= m[m3inv_pkg::COF_A[k]] * m[m3inv_pkg::COF_B[k]];
      pcd[k] <= m[m3inv_pkg::COF_C[k]] * m[m3inv_pkg::COF_D[k]];
    end
    e1[0] <= m[0];
    e1[1] <= m[3];
    e1[2] <= m[6];

    // stage 2
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      cof2[k] <= m3inv_pkg::COF_W'(pab[k]) - m3inv_pkg::COF_W'(pcd[k]);
    end
    e2 <= e1;

    // stage 3: det = m00*cof0 + m10*cof1 + m20*cof2
    for (int i = 0; i < 3; i++) begin
      plo[i] <= e2[i] * $signed({1'b0, cof2[i][m3inv_pkg::LO_W-1:0]});
      phi[i] <= e2[i] * $signed(cof2[i][m3inv_pkg::COF_W-1:m3inv_pkg::LO_W]);
    end
    cof3 <= cof2;

    // stage 4
    for (int i = 0; i < 3; i++) begin
      dterm[i] <= (m3inv_pkg::DET_W'(phi[i]) <<< m3inv_pkg::LO_W)
                  + m3inv_pkg::DET_W'(plo[i]);
    end
    cof4 <= cof3;

    // stage 5
    det5 <= dterm[0] + dterm[1] + dterm[2];
    cof5 <= cof4;

    // stage 6
    sing6 <= (det5 == '0);
    dmag6 <= det5[m3inv_pkg::DET_W-1] ? m3inv_pkg::DET_W'(-det5) : det5;
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      nmag6[k] <= cof5[k][m3inv_pkg::COF_W-1] ? m3inv_pkg::COF_W'(-cof5[k]) : cof5[k];
      sgn6[k]  <= cof5[k][m3inv_pkg::COF_W-1] ^ det5[m3inv_pkg::DET_W-1];
    end

    // stage 7: quotient of 2*|cof|*2^(2F)/|det| needs more than QB bits?
    dsing[0] <= sing6;
    dd[0]    <= dmag6;
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      rem[0][k] <= num_x[k];
      quo[0][k] <= '0;
      dsg[0][k] <= sgn6[k];
      dov[0][k] <= (num_x[k] >= dtop);
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (int j = 0; j < m3inv_pkg::QB; j++) begin
      dsing[j+1] <= dsing[j];
      dd[j+1]    <= dd[j];
      for (int k = 0; k < m3inv_pkg::NE; k++) begin
        dsg[j+1][k] <= dsg[j][k];
        dov[j+1][k] <= dov[j][k];
        if (rem[j][k] >= (m3inv_pkg::DIVW'(dd[j]) << (m3inv_pkg::QB - 1 - j))) begin
          rem[j+1][k] <= rem[j][k]
                         - (m3inv_pkg::DIVW'(dd[j]) << (m3inv_pkg::QB - 1 - j));
          quo[j+1][k] <= quo[j][k] | (m3inv_pkg::QB'(1) << (m3inv_pkg::QB - 1 - j));
        end else begin
          rem[j+1][k] <= rem[j][k];
          quo[j+1][k] <= quo[j][k];
        end
      end
    end
  end

  // ---- output stage: round half away, sign, saturate ----------------------
  localparam logic [m3inv_pkg::QB-1:0] LIM = m3inv_pkg::QB'(1) << (m3inv_pkg::DW - 1);

  logic [m3inv_pkg::QB:0]          qsum [m3inv_pkg::NE];
  logic [m3inv_pkg::QB-1:0]        qrnd [m3inv_pkg::NE];
  logic                            qneg [m3inv_pkg::NE];
  logic                            qovf [m3inv_pkg::NE];
  logic signed [m3inv_pkg::DW-1:0] qval [m3inv_pkg::NE];
  logic                            any_ovf;

  always_comb begin
    any_ovf = 1'b0;
    for (int k = 0; k < m3inv_pkg::NE; k++) begin
      qsum[k] = {1'b0, quo[m3inv_pkg::QB][k]} + (m3inv_pkg::QB+1)'(1);
      qrnd[k] = qsum[k][m3inv_pkg::QB:1];
      qneg[k] = dsg[m3inv_pkg::QB][k] && (qrnd[k] != '0);
      qovf[k] = dov[m3inv_pkg::QB][k]
                || (!qneg[k] && (qrnd[k] >= LIM))
                || (qneg[k] && (qrnd[k] > LIM));
      if (qovf[k]) begin
        qval[k] = qneg[k] ? {1'b1, {(m3inv_pkg::DW-1){1'b0}}}
                          : {1'b0, {(m3inv_pkg::DW-1){1'b1}}};
      end else if (qneg[k]) begin
        qval[k] = m3inv_pkg::DW'(-qrnd[k]);
      end else begin
        qval[k] = qrnd[k][m3inv_pkg::DW-1:0];
      end
      if (dsing[m3inv_pkg::QB]) qval[k] = '0;
      any_ovf = any_ovf | qovf[k];
    end
  end

  logic signed [m3inv_pkg::DW-1:0] res [m3inv_pkg::NE];
  logic                            res_sing;
  logic                            res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[m3inv_pkg::QB];
    end
    res      <= qval;
    res_sing <= dsing[m3inv_pkg::QB];
    res_ovf  <= any_ovf & ~dsing[m3inv_pkg::QB];
  end

  assign result.out_c0_r0  = res[0];
  assign result.out_c0_r1  = res[1];
  assign result.out_c0_r2  = res[2];
  assign result.out_c1_r0  = res[3];
  assign result.out_c1_r1  = res[4];
  assign result.out_c1_r2  = res[5];
  assign result.out_c2_r0  = res[6];
  assign result.out_c2_r1  = res[7];
  assign result.out_c2_r2  = res[8];
  assign result.singular   = res_sing;
  assign result.overflowed = res_ovf;

endmodule

`default_nettype wire

@@ verif/tb_matrix3_inverse.sv @@
// ----------------------------------------------------------------------------
// tb_matrix3_inverse: self-checking testbench for the 3x3 matrix inverse
// Drives matrices through the command port, predicts each inverse with exact
// wide-integer cofactor/determinant math and one rounded division per entry,
// and compares every done strobe field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class inverse_scoreboard;
  m3inv_pkg::out_t expected_q[$];
  int              errors;

  function new();
    errors = 0;
  endfunction

  // round(cof * 2^(2F) / det), ties away from zero, saturated to DW bits
  static function logic [m3inv_pkg::DW-1:0] divide_round(logic signed [127:0] cof,
                                                         logic signed [127:0] det,
                                                         ref bit ovf);
    logic [255:0] num, den, quo, rem, lim;
    bit neg;
    num = cof[127] ? 256'(-cof) : 256'(cof);
    den = det[127] ? 256'(-det) : 256'(det);
    num = num << (2 * m3inv_pkg::FB);
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) quo = quo + 1;
    neg = (cof[127] != det[127]) && (quo != 0);
    lim = 256'(1) << (m3inv_pkg::DW - 1);
    if (!neg && quo >= lim) begin
      ovf = 1;
      return {1'b0, {(m3inv_pkg::DW-1){1'b1}}};
    end
    if (neg && quo > lim) begin
      ovf = 1;
      return {1'b1, {(m3inv_pkg::DW-1){1'b0}}};
    end
    return neg ? m3inv_pkg::DW'(-quo) : m3inv_pkg::DW'(quo);
  endfunction

  static function m3inv_pkg::out_t invert(m3inv_pkg::in_t m);
    // entry index is 3*col + row; cofactor k = e[A]*e[B] - e[C]*e[D]
    int ia [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    int ib [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    int ic [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    int id [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
    logic signed [127:0] e [9];
    logic signed [127:0] cofs [9];
    logic signed [127:0] det;
    logic [m3inv_pkg::DW*9-1:0] flat;
    m3inv_pkg::out_t r;
    bit ovf;
    flat = m;
    for (int k = 0; k < 9; k++)
      e[k] = 128'(signed'(flat[m3inv_pkg::DW*(8-k) +: m3inv_pkg::DW]));
    for (int k = 0; k < 9; k++)
      cofs[k] = e[ia[k]] * e[ib[k]] - e[ic[k]] * e[id[k]];
    // first-row expansion: m00*C00 + m10*C01 + m20*C02
    det = e[0] * cofs[0] + e[3] * cofs[1] + e[6] * cofs[2];
    r = '0;
    ovf = 0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    flat = '0;
    for (int k = 0; k < 9; k++)
      flat[m3inv_pkg::DW*(8-k) +: m3inv_pkg::DW] = divide_round(cofs[k], det, ovf);
    r = {flat, 1'b0, ovf};
    return r;
  endfunction

  function void note_matrix(m3inv_pkg::in_t m);
    expected_q.push_back(invert(m));
  endfunction

  function void check_inverse(m3inv_pkg::out_t got);
    m3inv_pkg::out_t want;
    logic [m3inv_pkg::DW-1:0] w, g;
    if (expected_q.size() == 0) begin
      $error("inverse strobe with no matrix outstanding");
      errors++;
      return;
    end
    want = expected_q.pop_front();
    for (int k = 0; k < 9; k++) begin
      w = want[2 + m3inv_pkg::DW*(8-k) +: m3inv_pkg::DW];
      g = got[2 + m3inv_pkg::DW*(8-k) +: m3inv_pkg::DW];
      if (w !== g) begin
        $error("out_c%0d_r%0d: expected %h, actual %h", k / 3, k % 3, w, g);
        errors++;
      end
    end
    if (want.singular !== got.singular) begin
      $error("singular: expected %b, actual %b", want.singular, got.singular);
      errors++;
    end
    if (want.overflowed !== got.overflowed) begin
      $error("overflowed: expected %b, actual %b", want.overflowed, got.overflowed);
      errors++;
    end
  endfunction
endclass

module tb_matrix3_inverse;
  localparam int LATENCY   = 42;
  localparam int MAX_CYCLE = 200000;
  localparam logic [m3inv_pkg::DW-1:0] ONE  = m3inv_pkg::DW'(1) << m3inv_pkg::FB;
  localparam logic [m3inv_pkg::DW-1:0] MAXV = {1'b0, {(m3inv_pkg::DW-1){1'b1}}};
  localparam logic [m3inv_pkg::DW-1:0] MINV = {1'b1, {(m3inv_pkg::DW-1){1'b0}}};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  m3inv_pkg::in_t  operand = '0;
  logic            done;
  m3inv_pkg::out_t result;

  inverse_scoreboard sb = new();
  int cycle = 0;
  int idle_pct = 0;   // share of sender cycles left idle, percent

  matrix3_inverse DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // results cannot be held off: every done cycle is one transaction
  always @(posedge clk) begin
    if (!rst && done) sb.check_inverse(result);
  end

  // one transaction; each cycle before it idles with probability idle_pct
  task automatic send_matrix(m3inv_pkg::in_t m);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    operand <= m;
    do @(posedge clk); while (busy);
    sb.note_matrix(m);
  endtask

  function automatic m3inv_pkg::in_t from_entries(logic [m3inv_pkg::DW-1:0] a0, a1, a2,
                                                  b0, b1, b2, c0, c1, c2);
    return {a0, a1, a2, b0, b1, b2, c0, c1, c2};
  endfunction

  // entry near unity scale: a few integer units with random fraction
  function automatic logic [m3inv_pkg::DW-1:0] modest();
    return m3inv_pkg::DW'(signed'($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536);
  endfunction

  function automatic logic [m3inv_pkg::DW-1:0] any_entry();
    case ($urandom_range(4))
      0: return $urandom();
      1: return ($urandom_range(1)) ? MAXV : MINV;
      2: return m3inv_pkg::DW'(signed'($urandom_range(0, 64)) - 32);
      default: return modest();
    endcase
  endfunction

  task automatic random_matrix();
    logic [m3inv_pkg::DW-1:0] v [9];
    for (int k = 0; k < 9; k++) v[k] = ($urandom_range(3) == 0) ? any_entry() : modest();
    case ($urandom_range(9))
      0: for (int r = 0; r < 3; r++) v[6 + r] = v[r];           // duplicate column
      1: for (int c = 0; c < 3; c++) v[3*c + 2] = 0;             // zero row
      2: for (int k = 0; k < 9; k++) v[k] = $urandom();          // raw bits
      default: ;
    endcase
    send_matrix(from_entries(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, scaled, singular, extremes, tiny determinant
    idle_pct = 13;
    send_matrix(from_entries(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(from_entries(2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2));
    send_matrix('0);
    send_matrix(from_entries(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE,
                             7*ONE, 8*ONE, 9*ONE));
    send_matrix(from_entries(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
    send_matrix(from_entries(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
    send_matrix(from_entries(MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, 0, MAXV));
    send_matrix(from_entries(1, 0, 0, 0, 1, 0, 0, 0, 1));          // saturates
    send_matrix(from_entries(-1, 0, 0, 0, 1, 0, 0, 0, 1));         // negative saturation
    send_matrix(from_entries(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE));
    send_matrix(from_entries(3*ONE, 0, 0, 0, 3*ONE, 0, 0, 0, -3*ONE)); // rounding
    send_matrix(from_entries(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));    // permutation
    send_matrix(from_entries(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE)); // singular
    send_matrix('1);
    send_matrix(from_entries(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_matrix(from_entries(ONE, 5, 0, -7, ONE, 3, 0, 0, -ONE));

    // random, three sender pacing phases
    repeat (160) random_matrix();
    idle_pct = 84;
    repeat (160) random_matrix();
    idle_pct = 0;
    repeat (170) random_matrix();

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/m3inv_pkg.sv
hw/rtl/matrix3_inverse.sv
verif/tb_matrix3_inverse.sv
